[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define RMD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/rmd_pkg.sv]
// ----------------------------------------------------------------------------
// rmd_pkg
// Types and constants shared by the RESP message deframer modules.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned LenBitsDef   = 32;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned IndexBits    = 16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_SCALAR  = 3'd1,
    PH_LENLINE = 3'd2,
    PH_DATA    = 3'd3,
    PH_ACOUNT  = 3'd4,
    PH_ASTART  = 3'd5,
    PH_AINT    = 3'd6,
    PH_IGNORE  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_SIMPLE  = 3'd0,
    K_ERROR   = 3'd1,
    K_INTEGER = 3'd2,
    K_BULK    = 3'd3,
    K_ARRAY   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BADTYPE    = 2'd1,
    ST_BADFMT     = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef struct packed {
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic                 element_done;
    logic [IndexBits-1:0] element_index;
    logic [2:0]           resp_kind;
    logic                 msg_done;
    logic [1:0]           status;
  } result_t;

endpackage

[sv/rmd_intf.sv]
// ----------------------------------------------------------------------------
// rmd_in_if / rmd_out_if
// Valid/ready channels carrying message bytes in and deframed words out.
// ----------------------------------------------------------------------------
interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       msg_last;

  modport source (output valid, output rx_byte, output msg_last, input ready);
  modport sink   (input valid, input rx_byte, input msg_last, output ready);
endinterface

interface rmd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        element_done;
  logic [15:0] element_index;
  logic [2:0]  resp_kind;
  logic        msg_done;
  logic [1:0]  status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output element_done, output element_index, output resp_kind,
                  output msg_done, output status, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input element_done, input element_index, input resp_kind,
                  input msg_done, input status, output ready);
endinterface

[sv/rmd_core.sv]
// ----------------------------------------------------------------------------
// rmd_core
// Input register, deframer state and the per-byte step that yields one result.
// ----------------------------------------------------------------------------
module rmd_core
  import rmd_pkg::*;
#(
  parameter int unsigned LEN_BITS   = LenBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmd_in_if.sink     rx_i,
  input  logic       space_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       step;

  phase_e                phase_q, phase_d;
  kind_e                 kind_q, kind_d;
  logic [7:0]            h0_q, h0_d, h1_q, h1_d;
  logic [1:0]            hn_q, hn_d;
  logic [LEN_BITS-1:0]   len_q, len_d, tok_q, tok_d;
  logic [COUNT_BITS-1:0] want_q, want_d, done_q, done_d;
  status_e               err_q, err_d;

  logic                  push_en, clear_en, fail_en;
  status_e               fail_code;
  logic                  pv, ed, ei_set, prev_cr, is_digit;
  logic [7:0]            pb, c;
  logic [COUNT_BITS-1:0] ei_cnt, ei_sel;
  logic [LEN_BITS-1:0]   tok_inc, tok_line;
  logic [COUNT_BITS-1:0] done_inc, want_sat;
  logic [LEN_BITS+3:0]   acc10;
  logic                  acc_ovf;
  logic [LEN_BITS+COUNT_BITS-1:0] len_ext;
  logic [COUNT_BITS+IndexBits-1:0] ei_ext;

  assign rx_i.ready  = !s1_valid_q || space_i;
  assign step        = s1_valid_q && space_i;
  assign res_valid_o = step;
  assign c           = s1_byte_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
      s1_last_q <= rx_i.msg_last;
    end
  end

  assign prev_cr  = (hn_q == 2'd1 && h0_q == CH_CR) || (hn_q == 2'd2 && h1_q == CH_CR);
  assign is_digit = (c >= CH_D0) && (c <= CH_D9);
  assign tok_inc  = (&tok_q) ? tok_q : tok_q + 1'b1;
  assign tok_line = (hn_q == 2'd2) ? tok_inc : tok_q;
  assign done_inc = (&done_q) ? done_q : done_q + 1'b1;
  assign acc10    = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
                  + {{LEN_BITS{1'b0}}, c[3:0]};
  assign acc_ovf  = acc10[LEN_BITS+3:LEN_BITS] != 4'b0;
  assign len_ext  = {{COUNT_BITS{1'b0}}, len_q};
  assign want_sat = ((len_ext >> COUNT_BITS) != '0) ? {COUNT_BITS{1'b1}}
                                                    : len_ext[COUNT_BITS-1:0];

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    len_d     = len_q;
    tok_d     = tok_q;
    want_d    = want_q;
    done_d    = done_q;
    err_d     = err_q;
    push_en   = 1'b0;
    clear_en  = 1'b0;
    fail_en   = 1'b0;
    fail_code = ST_OK;
    pv        = 1'b0;
    pb        = 8'h00;
    ed        = 1'b0;
    ei_set    = 1'b0;
    ei_cnt    = '0;
    unique case (phase_q)
      PH_TYPE: begin
        clear_en = 1'b1;
        len_d    = '0;
        tok_d    = '0;
        priority if (c == CH_PLUS) begin
          kind_d  = K_SIMPLE;
          phase_d = PH_SCALAR;
        end else if (c == CH_MINUS) begin
          kind_d  = K_ERROR;
          phase_d = PH_SCALAR;
        end else if (c == CH_COLON) begin
          kind_d  = K_INTEGER;
          phase_d = PH_SCALAR;
        end else if (c == CH_DOLLAR) begin
          kind_d  = K_BULK;
          phase_d = PH_LENLINE;
        end else if (c == CH_STAR) begin
          kind_d  = K_ARRAY;
          phase_d = PH_ACOUNT;
        end else begin
          kind_d    = K_SIMPLE;
          fail_en   = 1'b1;
          fail_code = ST_BADTYPE;
        end
      end
      PH_SCALAR: begin
        if (hn_q == 2'd2) begin
          pv = 1'b1;
          pb = h0_q;
        end
        push_en = 1'b1;
      end
      PH_LENLINE, PH_ACOUNT: begin
        priority if (c == CH_LF && prev_cr) begin
          if (tok_q == '0) begin
            fail_en   = 1'b1;
            fail_code = ST_BADFMT;
          end else begin
            clear_en = 1'b1;
            tok_d    = '0;
            priority if (phase_q == PH_ACOUNT) begin
              want_d  = want_sat;
              done_d  = '0;
              phase_d = (want_sat == '0) ? PH_IGNORE : PH_ASTART;
            end else if (kind_q == K_BULK && len_q == '0) begin
              ed      = 1'b1;
              ei_set  = 1'b1;
              phase_d = PH_IGNORE;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end else if (prev_cr) begin
          fail_en   = 1'b1;
          fail_code = ST_BADFMT;
        end else if (c == CH_CR) begin
          push_en = 1'b1;
        end else if (is_digit) begin
          len_d   = acc_ovf ? {LEN_BITS{1'b1}} : acc10[LEN_BITS-1:0];
          tok_d   = tok_inc;
          push_en = 1'b1;
        end else begin
          fail_en   = 1'b1;
          fail_code = ST_BADFMT;
        end
      end
      PH_ASTART: begin
        clear_en = 1'b1;
        len_d    = '0;
        tok_d    = '0;
        priority if (c == CH_COLON) begin
          phase_d = PH_AINT;
        end else if (c == CH_DOLLAR) begin
          phase_d = PH_LENLINE;
        end else begin
          fail_en   = 1'b1;
          fail_code = ST_BADFMT;
        end
      end
      PH_DATA, PH_AINT: begin
        if (phase_q == PH_DATA && kind_q == K_BULK) begin
          pv    = 1'b1;
          pb    = c;
          tok_d = tok_inc;
          if (tok_inc >= len_q) begin
            ed      = 1'b1;
            ei_set  = 1'b1;
            phase_d = PH_IGNORE;
          end
        end else begin
          if (hn_q == 2'd2) begin
            pv    = 1'b1;
            pb    = h0_q;
            tok_d = tok_inc;
          end
          if (c == CH_LF && prev_cr) begin
            clear_en = 1'b1;
            if (phase_q == PH_DATA && (len_q == '0 || tok_line != len_q)) begin
              fail_en   = 1'b1;
              fail_code = ST_BADFMT;
            end else begin
              ed      = 1'b1;
              ei_set  = 1'b1;
              ei_cnt  = done_q;
              done_d  = done_inc;
              phase_d = (done_inc >= want_q) ? PH_IGNORE : PH_ASTART;
            end
          end else begin
            push_en = 1'b1;
          end
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (fail_en) begin
      phase_d = PH_IGNORE;
      if (err_q == ST_OK) begin
        err_d = fail_code;
      end
    end
  end

  always_comb begin
    h0_d = h0_q;
    h1_d = h1_q;
    hn_d = hn_q;
    priority if (clear_en || fail_en) begin
      h0_d = 8'h00;
      h1_d = 8'h00;
      hn_d = 2'd0;
    end else if (push_en) begin
      priority if (hn_q == 2'd2) begin
        h0_d = h1_q;
        h1_d = c;
      end else if (hn_q == 2'd1) begin
        h1_d = c;
        hn_d = 2'd2;
      end else begin
        h0_d = c;
        hn_d = 2'd1;
      end
    end
  end

  assign ei_sel = ei_set ? ei_cnt : ((kind_d == K_ARRAY) ? done_d : '0);
  assign ei_ext = {{IndexBits{1'b0}}, ei_sel};

  always_comb begin
    res_o.payload_valid = pv;
    res_o.payload_byte  = pb;
    res_o.element_done  = ed;
    res_o.element_index = ei_ext[IndexBits-1:0];
    res_o.resp_kind     = kind_d;
    res_o.msg_done      = s1_last_q;
    res_o.status        = ST_OK;
    if (s1_last_q) begin
      if (phase_d == PH_SCALAR || (phase_d == PH_DATA && kind_d == K_BULK)) begin
        res_o.element_done  = 1'b1;
        res_o.element_index = '0;
      end
      priority if (err_d != ST_OK) begin
        res_o.status = err_d;
      end else if (kind_d == K_ARRAY && phase_d != PH_IGNORE) begin
        res_o.status = ST_INCOMPLETE;
      end else begin
        res_o.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= K_SIMPLE;
      h0_q    <= 8'h00;
      h1_q    <= 8'h00;
      hn_q    <= 2'd0;
      len_q   <= '0;
      tok_q   <= '0;
      want_q  <= '0;
      done_q  <= '0;
      err_q   <= ST_OK;
    end else if (step) begin
      if (s1_last_q) begin
        phase_q <= PH_TYPE;
        kind_q  <= K_SIMPLE;
        h0_q    <= 8'h00;
        h1_q    <= 8'h00;
        hn_q    <= 2'd0;
        len_q   <= '0;
        tok_q   <= '0;
        want_q  <= '0;
        done_q  <= '0;
        err_q   <= ST_OK;
      end else begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        h0_q    <= h0_d;
        h1_q    <= h1_d;
        hn_q    <= hn_d;
        len_q   <= len_d;
        tok_q   <= tok_d;
        want_q  <= want_d;
        done_q  <= done_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

[sv/rmd_outbuf.sv]
// ----------------------------------------------------------------------------
// rmd_outbuf
// Two-word result buffer that decouples the step logic from the output side.
// ----------------------------------------------------------------------------
module rmd_outbuf
  import rmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    e0_q, e0_d, e1_q, e1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign data_o  = e0_q;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q;
    priority if (push_i && pop) begin
      if (cnt_q == 2'd2) begin
        e0_d = e1_q;
        e1_d = data_i;
      end else begin
        e0_d = data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        e0_d = data_i;
      end else begin
        e1_d = data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (pop) begin
      e0_d  = e1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

[sv/resp_message_deframer_top.sv]
// ----------------------------------------------------------------------------
// resp_message_deframer_top
// Streaming RESP2 deframer: one message byte in, one status/payload word out.
// ----------------------------------------------------------------------------
//  port   | dir | words carried
//  rx_i   | in  | rx_byte, msg_last
//  tx_o   | out | payload_valid/byte, element_done/index, resp_kind, msg_done, status
//
//  One byte per cycle sustained unless tx_o stalls; a word is offered on tx_o once its
//  byte has passed the input register and the step logic into a two-word result buffer.
//  Asynchronous reset clears all message state; the block is ready at once.
//  A stalled output fills the buffer, then the input register, then drops rx_i.ready.
module resp_message_deframer_top
  import rmd_pkg::*;
#(
  parameter int unsigned LEN_BITS   = LenBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmd_in_if.sink    rx_i,
  rmd_out_if.source tx_o
);

  logic    res_valid, space;
  result_t res, head;

  rmd_core #(
    .LEN_BITS  (LEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .space_i    (space),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  rmd_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .space_o(space),
    .valid_o(tx_o.valid),
    .ready_i(tx_o.ready),
    .data_o (head)
  );

  assign tx_o.payload_valid = head.payload_valid;
  assign tx_o.payload_byte  = head.payload_byte;
  assign tx_o.element_done  = head.element_done;
  assign tx_o.element_index = head.element_index;
  assign tx_o.resp_kind     = head.resp_kind;
  assign tx_o.msg_done      = head.msg_done;
  assign tx_o.status        = head.status;

endmodule

[sv/rmd_checker.sv]
// ----------------------------------------------------------------------------
// rmd_checker
// Port-level checks on the deframer output words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmd_checker
  import rmd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        payload_valid_i,
  input logic [7:0]  payload_byte_i,
  input logic [15:0] element_index_i,
  input logic [2:0]  resp_kind_i,
  input logic        msg_done_i,
  input logic [1:0]  status_i
);

  logic       status_stray, byte_stray, index_stray, stall_hold, word_kept;
  logic [9:0] word_q;

  assign status_stray = valid_i && !msg_done_i && status_i != ST_OK;
  assign byte_stray   = valid_i && !payload_valid_i && payload_byte_i != 8'h00;
  assign index_stray  = valid_i && resp_kind_i != K_ARRAY && element_index_i != 16'h0000;
  assign stall_hold   = valid_i && !ready_i;
  assign word_kept    = valid_i && ({status_i, payload_byte_i} == word_q);

  always_ff @(posedge clk_i) begin
    word_q <= {status_i, payload_byte_i};
  end

  `RMD_NEVER(a_status_on_done, clk_i, rst_ni, status_stray, "status set without msg_done")
  `RMD_NEVER(a_byte_zero, clk_i, rst_ni, byte_stray, "payload_byte set without payload_valid")
  `RMD_NEVER(a_index_scalar, clk_i, rst_ni, index_stray, "element index on a scalar")
  `RMD_ASSERT(a_hold_stall, clk_i, rst_ni, stall_hold |=> word_kept, "word changed under stall")

endmodule

bind resp_message_deframer_top rmd_checker u_rmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (tx_o.valid),
  .ready_i        (tx_o.ready),
  .payload_valid_i(tx_o.payload_valid),
  .payload_byte_i (tx_o.payload_byte),
  .element_index_i(tx_o.element_index),
  .resp_kind_i    (tx_o.resp_kind),
  .msg_done_i     (tx_o.msg_done),
  .status_i       (tx_o.status)
);
